### hw/rtl/ssfa_pkg.sv
// Shared constants and the single-precision magnitude add function.
`timescale 1ns / 1ps
package ssfa_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ExpW    = 8;
  localparam int unsigned FracW   = 23;
  localparam int unsigned GuardW  = 6;
  localparam int unsigned MantW   = FracW + 1 + GuardW + 1; // 31 bits, carry included
  localparam logic [ExpW-1:0] ExpMax = 8'hFF;
  localparam logic [MantW-1:0] HalfUlp = 31'(32'h1 << 5);

  // Full behaviour of the adder for one operand pair.
  function automatic logic [WordW-1:0] ssfa_add(input logic [WordW-1:0] a,
                                                 input logic [WordW-1:0] b);
    logic [ExpW-1:0]  ea, eb, big_e, small_e;
    logic [FracW-1:0] fa, fb, big_fr, small_fr;
    logic             nan_a, nan_b, swap, sign;
    logic [ExpW:0]    shamt, exp1, exp2;
    logic [MantW-1:0] big_m, small_m, sum1, norm1, sum2, norm2;
    logic [FracW:0]   den_sum;
    logic [WordW-1:0] res;
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    sign = a[31];
    nan_a = (ea == ExpMax) && (fa != '0);
    nan_b = (eb == ExpMax) && (fb != '0);
    swap = ea < eb;
    big_e    = swap ? eb : ea;
    small_e  = swap ? ea : eb;
    big_fr   = swap ? fb : fa;
    small_fr = swap ? fa : fb;
    shamt = {1'b0, big_e} - {1'b0, small_e};
    if (small_e == '0) begin
      shamt = shamt - 9'd1;
    end
    big_m   = {1'b0, 1'b1, big_fr, {GuardW{1'b0}}};
    small_m = {1'b0, (small_e != '0), small_fr, {GuardW{1'b0}}};
    sum1 = big_m + ((shamt > 9'd30) ? '0 : (small_m >> shamt[4:0]));
    exp1 = {1'b0, big_e} + {8'd0, sum1[MantW-1]};
    norm1 = sum1[MantW-1] ? (sum1 >> 1) : sum1;
    sum2 = norm1 + HalfUlp;
    exp2 = exp1 + {8'd0, sum2[MantW-1]};
    norm2 = sum2[MantW-1] ? (sum2 >> 1) : sum2;
    den_sum = {1'b0, fa} + {1'b0, fb};
    if (swap) begin
      if (nan_b || eb == ExpMax) begin
        res = b;
      end else if (shamt >= 9'd25) begin
        res = {sign, big_e, big_fr};
      end else if (exp2 >= {1'b0, ExpMax}) begin
        res = {sign, ExpMax, {FracW{1'b0}}};
      end else begin
        res = {sign, exp2[ExpW-1:0], norm2[GuardW +: FracW]};
      end
    end else if (nan_a || nan_b) begin
      res = nan_a ? a : b;
    end else if (ea == ExpMax) begin
      res = a;
    end else if (big_e == '0) begin
      res = {sign, 7'd0, den_sum};
    end else if (shamt >= 9'd25) begin
      res = {sign, big_e, big_fr};
    end else if (exp2 >= {1'b0, ExpMax}) begin
      res = {sign, ExpMax, {FracW{1'b0}}};
    end else begin
      res = {sign, exp2[ExpW-1:0], norm2[GuardW +: FracW]};
    end
    return res;
  endfunction

endpackage

### hw/rtl/same_sign_float32_add.sv
// Top level of the same-sign single-precision adder.
`timescale 1ns / 1ps
// Usage: present a request of two single-precision words on operand_a_i and
// operand_b_i with in_valid_i high; it is taken at a clock edge where
// in_stall_o is low. The sum appears on sum_word_o with out_valid_o high in the
// cycle after acceptance, and leaves at an edge where out_stall_i is low.
// Throughput is one request per cycle while the receiver does not stall: the add,
// alignment, normalisation and rounding sit in one combinational path before
// the result register, which holds the sum until it is taken.
// When the receiver stalls, the result register holds its word and the block
// stalls the sender; as soon as the result is taken a new request may enter
// in the same cycle. Reset empties the result register, so no result is
// shown after reset until a request is accepted.
// NaN and infinity operands pass through, denormal pairs add directly, and
// rounding adds half an ulp and truncates.
module same_sign_float32_add import ssfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WordW-1:0] operand_a_i,
  input  logic [WordW-1:0] operand_b_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] sum_word_o
);
  ssfa_core u_core (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operand_a_i, .operand_b_i,
    .out_valid_o, .out_stall_i, .sum_word_o
  );
endmodule

### hw/rtl/ssfa_core.sv
// Combinational add logic feeding a result register with stall control.
`timescale 1ns / 1ps
module ssfa_core import ssfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WordW-1:0] operand_a_i,
  input  logic [WordW-1:0] operand_b_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] sum_word_o
);
  logic             full_q, full_d;
  logic [WordW-1:0] res_q, res_d;
  logic             take;

  // The result register empties and refills in the same cycle.
  assign in_stall_o = full_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;
  assign full_d     = take || (full_q && out_stall_i);
  assign res_d      = ssfa_add(operand_a_i, operand_b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = full_q;
  assign sum_word_o  = res_q;
endmodule

### hw/rtl/ssfa_checker.sv
// Port-level assertions for the adder, bound to the top level.
`timescale 1ns / 1ps
module ssfa_checker import ssfa_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WordW-1:0] sum_word_o
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sum_word_o))
    else $error("stalled result changed");
  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request gave no result");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_valid_i |=> !out_valid_o)
    else $error("result repeated");
endmodule

bind same_sign_float32_add ssfa_checker u_ssfa_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .sum_word_o
);
